@@ src/psmw_pkg.sv @@
`default_nettype none
package psmw_pkg;

	localparam int K_BITS = 24;
	localparam int SCALE_BITS = 14;
	localparam logic [K_BITS-1:0] WIDTH_MAX = 24'd10000000;
	localparam logic [SCALE_BITS-1:0] SCALE = 14'd10000;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_PAIR,
		B_RD_J,
		B_LAT_J,
		B_LEN,
		B_WALK,
		B_DRAIN,
		B_EVAL,
		B_ROOT,
		B_NEXT,
		B_DONE
	} back_state_t;

	typedef enum logic [2:0] {
		R_IDLE,
		R_SQ,
		R_SCALE,
		R_DELTA,
		R_STEP,
		R_DONE
	} root_state_t;

endpackage
`default_nettype wire

@@ src/psmw_root.sv @@
`default_nettype none
module psmw_root
	import psmw_pkg::*;
#(
	parameter int CW = 35,
	parameter int LW = 35
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [CW-1:0]     cross_mag,
	input  wire logic [LW-1:0]     len2,
	output logic                   done,
	output logic [K_BITS-1:0]      width
);

	localparam int TW = 2 * CW + SCALE_BITS;
	localparam int AW = ((TW > LW + 2 * K_BITS + 1) ? TW : LW + 2 * K_BITS + 1) + 1;
	localparam int BW = $clog2(K_BITS);

	root_state_t state_q, state_d;

	logic [AW-1:0]     mcand_q, acc_q, rres_q, skl_q, sl_q, delta_q;
	logic [CW-1:0]     mplier_q;
	logic [K_BITS-1:0] k_q, res_q;
	logic [BW-1:0]     b_q;
	logic [AW-1:0]     acc_add, skl_acc;
	logic              take;
	logic [K_BITS:0]   kp1;

	assign acc_add = mplier_q[0] ? acc_q + mcand_q : acc_q;
	assign take    = delta_q < rres_q;
	assign skl_acc = take ? skl_q + (sl_q << 1) : skl_q;
	assign kp1     = {1'b0, k_q} + (K_BITS + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= R_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		case (state_q)
			R_IDLE: if (start) state_d = (cross_mag == '0) ? R_DONE : R_SQ;
			R_SQ: if (mplier_q == '0) state_d = R_SCALE;
			R_SCALE: if (mplier_q == '0) state_d = R_DELTA;
			R_DELTA: state_d = R_STEP;
			R_STEP: state_d = (b_q == '0) ? R_DONE : R_DELTA;
			R_DONE: begin
				done    = 1'b1;
				state_d = R_IDLE;
			end
			default: state_d = R_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				mcand_q  <= AW'(cross_mag);
				mplier_q <= cross_mag;
				acc_q    <= '0;
				res_q    <= '0;
			end
			R_SQ, R_SCALE: begin
				if (mplier_q == '0) begin
					// square done: scale by 10000; scale done: open the root search
					mcand_q  <= acc_q;
					mplier_q <= CW'(SCALE);
					acc_q    <= '0;
					rres_q   <= acc_q;
					skl_q    <= '0;
					sl_q     <= AW'(len2) << (2 * (K_BITS - 1));
					k_q      <= '0;
					b_q      <= BW'(K_BITS - 1);
				end else begin
					acc_q    <= acc_add;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
			end
			R_DELTA: delta_q <= skl_q + sl_q;
			R_STEP: begin
				if (take) begin
					rres_q <= rres_q - delta_q;
					k_q    <= k_q | (K_BITS'(1) << b_q);
				end
				skl_q <= skl_acc >> 1;
				sl_q  <= sl_q >> 2;
				b_q   <= b_q - BW'(1);
				if (b_q == '0) begin
					// largest k still short of the target, plus one
					if (take) begin
						res_q <= ((kp1 + (K_BITS + 1)'(1)) > (K_BITS + 1)'(WIDTH_MAX))
							? WIDTH_MAX : K_BITS'(kp1 + (K_BITS + 1)'(1));
					end else begin
						res_q <= (kp1 > (K_BITS + 1)'(WIDTH_MAX)) ? WIDTH_MAX : K_BITS'(kp1);
					end
				end
			end
			default: ;
		endcase
	end

	assign width = res_q;

endmodule
`default_nettype wire

@@ src/psmw_queue.sv @@
`default_nettype none
module psmw_queue
	import psmw_pkg::*;
#(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data,
	output q_stat_t           stat
);

	logic [W-1:0] slot_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !stat.full) wp_q <= ~wp_q;
			if (pop && !stat.empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && !stat.full) - 2'(pop && !stat.empty);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !stat.full) slot_q[wp_q] <= push_data;
	end

	assign pop_data   = slot_q[rp_q];
	assign stat.empty = cnt_q == 2'd0;
	assign stat.full  = cnt_q == 2'd2;

endmodule
`default_nettype wire

@@ src/psmw_front.sv @@
`default_nettype none
module psmw_front
	import psmw_pkg::*;
#(
	parameter int MAX_POINTS = 128,
	parameter int COORD_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic signed [COORD_BITS-1:0]          point_x,
	input  wire logic signed [COORD_BITS-1:0]          point_y,
	input  wire logic                                  last_point,
	input  wire logic                                  back_busy,
	input  wire q_stat_t                               q_stat,
	output logic                                       busy,
	output logic                                       wr_en,
	output logic [$clog2(MAX_POINTS)-1:0]              wr_addr,
	output logic signed [COORD_BITS-1:0]               wr_x,
	output logic signed [COORD_BITS-1:0]               wr_y,
	output logic                                       push,
	output logic [$clog2(MAX_POINTS+1)-1:0]            push_n
);

	localparam int AB = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	logic [CNT_W-1:0] count_q;
	logic             accept, room;

	// hold off while a closed set waits or is walked: the store is single-buffered
	assign busy   = !q_stat.empty || q_stat.full || back_busy;
	assign accept = start && !busy;
	assign room   = count_q < CNT_W'(MAX_POINTS);

	assign wr_en   = accept && room;
	assign wr_addr = count_q[AB-1:0];
	assign wr_x    = point_x;
	assign wr_y    = point_y;
	assign push    = accept && last_point;
	assign push_n  = room ? count_q + CNT_W'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (push) count_q <= '0;
		else if (wr_en) count_q <= count_q + CNT_W'(1);
	end

endmodule
`default_nettype wire

@@ src/psmw_back.sv @@
`default_nettype none
module psmw_back
	import psmw_pkg::*;
#(
	parameter int MAX_POINTS = 128,
	parameter int COORD_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  wr_en,
	input  wire logic [$clog2(MAX_POINTS)-1:0]         wr_addr,
	input  wire logic signed [COORD_BITS-1:0]          wr_x,
	input  wire logic signed [COORD_BITS-1:0]          wr_y,
	input  wire q_stat_t                               q_stat,
	input  wire logic [$clog2(MAX_POINTS+1)-1:0]       q_n,
	output logic                                       pop,
	output logic                                       back_busy,
	output logic                                       result_valid,
	output logic [K_BITS-1:0]                          width_hundredths,
	output logic                                       no_support_line
);

	localparam int AB = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int IW = CNT_W + 1;
	localparam int DW = COORD_BITS + 1;
	localparam int CW = 2 * DW + 1;
	localparam int LW = 2 * DW + 1;

	logic signed [COORD_BITS-1:0] mem_x [MAX_POINTS];
	logic signed [COORD_BITS-1:0] mem_y [MAX_POINTS];
	logic signed [COORD_BITS-1:0] rx_q, ry_q, xi_q, yi_q;
	logic [AB-1:0]                rd_addr;

	back_state_t state_d, state_q;

	logic [CNT_W-1:0]       n_q;
	logic [IW-1:0]          i_q, j_q, kc_q;
	logic signed [DW-1:0]   dx_q, dy_q, ddx, ddy;
	logic signed [2*DW-1:0] p1_s2, p2_s2, sqx, sqy;
	logic signed [CW-1:0]   cr;
	logic [CW-1:0]          mag, pos_q, neg_q, cmag;
	logic [LW-1:0]          len2_q;
	logic                   v_s1, v_s2, issue;
	logic                   found_q;
	logic [K_BITS-1:0]      best_q, root_w;
	logic                   root_start, root_done;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= wr_x;
			mem_y[wr_addr] <= wr_y;
		end
		rx_q <= mem_x[rd_addr];
		ry_q <= mem_y[rd_addr];
	end

	assign ddx  = DW'(rx_q) - DW'(xi_q);
	assign ddy  = DW'(ry_q) - DW'(yi_q);
	assign cr   = CW'(p1_s2) - CW'(p2_s2);
	assign mag  = cr[CW-1] ? CW'(-cr) : CW'(cr);
	assign sqx  = dx_q * dx_q;
	assign sqy  = dy_q * dy_q;
	assign cmag = (pos_q != '0) ? pos_q : neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
		end
	end

	always_comb begin
		state_d      = state_q;
		rd_addr      = i_q[AB-1:0];
		issue        = 1'b0;
		pop          = 1'b0;
		root_start   = 1'b0;
		result_valid = 1'b0;
		case (state_q)
			B_IDLE: if (!q_stat.empty) begin
				pop     = 1'b1;
				state_d = B_PAIR;
			end
			B_PAIR: state_d = (j_q >= IW'(n_q)) ? B_DONE : B_RD_J;
			B_RD_J: begin
				rd_addr = j_q[AB-1:0];
				state_d = B_LAT_J;
			end
			B_LAT_J: state_d = B_LEN;
			B_LEN: state_d = (dx_q == '0 && dy_q == '0) ? B_NEXT : B_WALK;
			B_WALK: begin
				rd_addr = kc_q[AB-1:0];
				issue   = 1'b1;
				if (kc_q == IW'(n_q) - IW'(1)) state_d = B_DRAIN;
			end
			B_DRAIN: if (!v_s1 && !v_s2) state_d = B_EVAL;
			B_EVAL: begin
				if (pos_q != '0 && neg_q != '0) begin
					state_d = B_NEXT;
				end else begin
					root_start = 1'b1;
					state_d    = B_ROOT;
				end
			end
			B_ROOT: if (root_done) state_d = B_NEXT;
			B_NEXT: state_d = B_PAIR;
			B_DONE: begin
				result_valid = 1'b1;
				state_d      = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			p1_s2 <= dx_q * ddy;
			p2_s2 <= dy_q * ddx;
		end
		if (v_s2) begin
			if (!cr[CW-1] && mag > pos_q) pos_q <= mag;
			if (cr[CW-1] && mag > neg_q) neg_q <= mag;
		end
		case (state_q)
			B_IDLE: begin
				n_q     <= q_n;
				i_q     <= '0;
				j_q     <= IW'(1);
				found_q <= 1'b0;
				best_q  <= '0;
			end
			B_RD_J: begin
				xi_q <= rx_q;
				yi_q <= ry_q;
			end
			B_LAT_J: begin
				dx_q <= DW'(rx_q) - DW'(xi_q);
				dy_q <= DW'(ry_q) - DW'(yi_q);
			end
			B_LEN: begin
				len2_q <= LW'($unsigned(sqx)) + LW'($unsigned(sqy));
				kc_q   <= '0;
				pos_q  <= '0;
				neg_q  <= '0;
			end
			B_WALK: kc_q <= kc_q + IW'(1);
			B_ROOT: if (root_done && (!found_q || root_w < best_q)) begin
				best_q  <= root_w;
				found_q <= 1'b1;
			end
			B_NEXT: begin
				if (j_q + IW'(1) < IW'(n_q)) begin
					j_q <= j_q + IW'(1);
				end else begin
					i_q <= i_q + IW'(1);
					j_q <= i_q + IW'(2);
				end
			end
			default: ;
		endcase
	end

	psmw_root #(
		.CW(CW),
		.LW(LW)
	) u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (root_start),
		.cross_mag (cmag),
		.len2      (len2_q),
		.done      (root_done),
		.width     (root_w)
	);

	assign back_busy        = state_q != B_IDLE;
	assign width_hundredths = found_q ? best_q : '0;
	assign no_support_line  = !found_q;

endmodule
`default_nettype wire

@@ src/point_set_min_width_unit.sv @@
`default_nettype none
// Minimum width of a point set over supporting lines, in hundredths.
//
// Input: drive point_x, point_y, last_point with start; a beat is taken on a
// clock edge where start is high and busy is low. Points load one per cycle
// while busy is low into a MAX_POINTS-entry store; extra points are dropped,
// but their last flag still closes the set.
// Output: one beat per closed set, on result_valid for a single cycle. The
// receiver cannot stall it. no_support_line is high (width 0) when no pair of
// distinct points leaves all points on one side.
// Operation: the last point starts a walk over all pairs i<j, each reading the
// point store once per point through its single read port, then shift-add
// squaring, scaling and a bit-serial square root for each one-sided pair.
// busy stays high from the last point until the result.
// Reset clears the point count and control; the store needs no clearing.
module point_set_min_width_unit
	import psmw_pkg::*;
#(
	parameter int MAX_POINTS = 128,
	parameter int COORD_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [COORD_BITS-1:0] point_x,
	input  wire logic signed [COORD_BITS-1:0] point_y,
	input  wire logic                         last_point,
	output logic                              result_valid,
	output logic [K_BITS-1:0]                 width_hundredths,
	output logic                              no_support_line
);

	localparam int AB = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	q_stat_t                      q_stat;
	logic                         back_busy, wr_en, push, pop;
	logic [AB-1:0]                wr_addr;
	logic signed [COORD_BITS-1:0] wr_x, wr_y;
	logic [CNT_W-1:0]             push_n, q_n;

	psmw_front #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.point_x    (point_x),
		.point_y    (point_y),
		.last_point (last_point),
		.back_busy  (back_busy),
		.q_stat     (q_stat),
		.busy       (busy),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_x       (wr_x),
		.wr_y       (wr_y),
		.push       (push),
		.push_n     (push_n)
	);

	psmw_queue #(
		.W(CNT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_n),
		.pop       (pop),
		.pop_data  (q_n),
		.stat      (q_stat)
	);

	psmw_back #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.wr_en            (wr_en),
		.wr_addr          (wr_addr),
		.wr_x             (wr_x),
		.wr_y             (wr_y),
		.q_stat           (q_stat),
		.q_n              (q_n),
		.pop              (pop),
		.back_busy        (back_busy),
		.result_valid     (result_valid),
		.width_hundredths (width_hundredths),
		.no_support_line  (no_support_line)
	);

endmodule
`default_nettype wire

@@ src/psmw_checker.sv @@
`default_nettype none
module psmw_checker
	import psmw_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              last_point,
	input wire logic              result_valid,
	input wire logic [K_BITS-1:0] width_hundredths,
	input wire logic              no_support_line
);

	// a closed set locks the port until its result is out
	a_last_locks: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_point |=> busy)
		else $error("port open right after last point");

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> width_hundredths <= WIDTH_MAX)
		else $error("width beyond saturation");

	a_no_line_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && no_support_line |-> width_hundredths == '0)
		else $error("width nonzero with no support line");

endmodule

bind point_set_min_width_unit psmw_checker u_psmw_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.last_point       (last_point),
	.result_valid     (result_valid),
	.width_hundredths (width_hundredths),
	.no_support_line  (no_support_line)
);
`default_nettype wire

@@ tb/sv/tb.sv @@
`default_nettype none
module tb;
	import psmw_pkg::*;

	localparam int MAX_PTS = 128;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [15:0] point_x = '0;
	logic signed [15:0] point_y = '0;
	logic last_point = 1'b0;
	wire logic busy;
	wire logic result_valid;
	wire logic [K_BITS-1:0] width_hundredths;
	wire logic no_support_line;

	point_set_min_width_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point_x(point_x), .point_y(point_y), .last_point(last_point),
		.result_valid(result_valid), .width_hundredths(width_hundredths),
		.no_support_line(no_support_line)
	);

	always #4 clk = ~clk;

	typedef struct {
		logic [K_BITS-1:0] width;
		logic none;
	} width_result_t;

	longint pt_x[MAX_PTS];
	longint pt_y[MAX_PTS];
	int pt_count = 0;
	width_result_t pending_widths[$];
	int errors = 0;
	int points_sent = 0;
	int sets_closed = 0;
	int widths_seen = 0;
	bit allow_gaps = 1'b1;

	task automatic report(input string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	function automatic logic [K_BITS-1:0] to_hundredths(input longint unsigned c,
			input longint unsigned len2);
		logic [127:0] tgt, scaled, wmax;
		longint unsigned lo, hi, mid;
		if (c == 0)
			return '0;
		scaled = 128'(c) * 128'd100;
		tgt = scaled * scaled;
		wmax = 128'(WIDTH_MAX);
		if (wmax * wmax * 128'(len2) < tgt)
			return WIDTH_MAX;
		lo = 0;
		hi = 64'(WIDTH_MAX);
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (128'(mid) * 128'(mid) * 128'(len2) >= tgt)
				hi = mid;
			else
				lo = mid + 1;
		end
		return lo[K_BITS-1:0];
	endfunction

	function automatic width_result_t min_support_width();
		width_result_t r;
		longint dx, dy, cr;
		longint unsigned pos, neg, len2;
		logic [K_BITS-1:0] w;
		r.width = '0;
		r.none = 1'b1;
		for (int i = 0; i < pt_count; i++)
			for (int j = i + 1; j < pt_count; j++) begin
				dx = pt_x[j] - pt_x[i];
				dy = pt_y[j] - pt_y[i];
				if (dx == 0 && dy == 0)
					continue;
				pos = 0;
				neg = 0;
				for (int k = 0; k < pt_count; k++) begin
					cr = dx * (pt_y[k] - pt_y[i]) - dy * (pt_x[k] - pt_x[i]);
					if (cr > 0 && longint'(pos) < cr)
						pos = cr;
					if (cr < 0 && longint'(neg) < -cr)
						neg = -cr;
				end
				if (pos != 0 && neg != 0)
					continue;
				len2 = dx * dx + dy * dy;
				w = to_hundredths(pos != 0 ? pos : neg, len2);
				if (r.none || w < r.width) begin
					r.width = w;
					r.none = 1'b0;
				end
			end
		return r;
	endfunction

	// drive one beat and wait until it is taken
	task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
			input bit last);
		@(negedge clk);
		start <= 1'b1;
		point_x <= x;
		point_y <= y;
		last_point <= last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		points_sent++;
		if (pt_count < MAX_PTS) begin
			pt_x[pt_count] = x;
			pt_y[pt_count] = y;
			pt_count++;
		end
		if (last) begin
			pending_widths.insert(pending_widths.size(), min_support_width());
			pt_count = 0;
			sets_closed++;
		end
	endtask

	task automatic idle_sender();
		if (allow_gaps && $urandom_range(3) == 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(16)) @(negedge clk);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_widths.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [15:0] pick_coord(input int spread);
		if (spread == 0)
			return 16'($urandom);
		return $signed(16'($urandom_range(2 * spread))) - 16'(spread);
	endfunction

	always @(posedge clk) begin
		if (result_valid) begin
			widths_seen++;
			if (pending_widths.size() == 0) begin
				report("result beat with nothing expected");
			end else begin
				width_result_t e;
				e = pending_widths.pop_front();
				if (width_hundredths !== e.width)
					report($sformatf("width_hundredths %0d, expected %0d",
						width_hundredths, e.width));
				if (no_support_line !== e.none)
					report($sformatf("no_support_line %b, expected %b",
						no_support_line, e.none));
			end
		end
	end

	task automatic test_corner_sets();
		send_point(16'sd5, -16'sd7, 1'b1);                  // single point
		send_point(16'sd3, 16'sd3, 1'b0);                   // all coincident
		send_point(16'sd3, 16'sd3, 1'b1);
		send_point(-16'sd32768, -16'sd32768, 1'b0);         // two extreme points
		send_point(16'sd32767, 16'sd32767, 1'b1);
		send_point(16'sd0, 16'sd0, 1'b0);                   // collinear set
		send_point(16'sd10, 16'sd20, 1'b0);
		send_point(-16'sd5, -16'sd10, 1'b1);
		send_point(-16'sd32768, -16'sd32768, 1'b0);         // full-range square
		send_point(16'sd32767, 16'sd32767, 1'b0);
		send_point(-16'sd32768, 16'sd32767, 1'b0);
		send_point(16'sd32767, -16'sd32768, 1'b1);
		send_point(16'sd0, 16'sd0, 1'b0);                   // unit square, one corner repeated
		send_point(16'sd1, 16'sd0, 1'b0);
		send_point(16'sd0, 16'sd1, 1'b0);
		send_point(16'sd1, 16'sd1, 1'b0);
		send_point(16'sd1, 16'sd1, 1'b1);
		settle();
	endtask

	task automatic test_store_full();
		for (int i = 0; i < MAX_PTS + 3; i++)
			send_point(pick_coord(i % 2 ? 0 : 50), pick_coord(i % 2 ? 0 : 50),
				i == MAX_PTS + 2);
		settle();
	endtask

	task automatic test_random_sets();
		int n, spread;
		while (points_sent < 550) begin
			if (points_sent > 450)
				allow_gaps = 1'b0;
			n = $urandom_range(3) == 0 ? $urandom_range(1, 12) : $urandom_range(2, 6);
			spread = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 40);
			for (int i = 0; i < n; i++) begin
				idle_sender();
				send_point(pick_coord(spread), pick_coord(spread), i == n - 1);
			end
			if ($urandom_range(15) == 0)
				settle();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_corner_sets();
		test_store_full();
		test_random_sets();
		settle();
		repeat (200) @(posedge clk);
		$display("%0d points in %0d sets, %0d widths checked, including corner sets",
			points_sent, sets_closed, widths_seen);
		$display("and one set overflowing the %0d-entry store", MAX_PTS);
		if (errors == 0 && pending_widths.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#400000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
